>>> src/glp_pkg.sv
// ----------------------------------------------------------------------------
// glp_pkg
// Shared types and constants for the G-code line parser.
// ----------------------------------------------------------------------------
package glp_pkg;

    localparam int CFG_W = 20;
    localparam logic [31:0] MAG_CAP = 32'h8000_0000;

    localparam logic [0:0] CFG_SLOW   = 1'd0;
    localparam logic [0:0] CFG_MEDIUM = 1'd1;

    localparam logic [2:0] CMD_BLANK = 3'd0;
    localparam logic [2:0] CMD_G0    = 3'd1;
    localparam logic [2:0] CMD_G1    = 3'd2;
    localparam logic [2:0] CMD_G28   = 3'd3;
    localparam logic [2:0] CMD_G92   = 3'd4;
    localparam logic [2:0] CMD_M2    = 3'd5;
    localparam logic [2:0] CMD_ERR   = 3'd6;

    localparam logic [1:0] FEED_NONE   = 2'd0;
    localparam logic [1:0] FEED_SLOW   = 2'd1;
    localparam logic [1:0] FEED_MEDIUM = 2'd2;
    localparam logic [1:0] FEED_FAST   = 2'd3;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_LEAD   = 7'b0000010,
        PH_SIGNED = 7'b0000100,
        PH_INT    = 7'b0001000,
        PH_POINT  = 7'b0010000,
        PH_FRAC   = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic              status;
        logic [2:0]        command;
        logic              has_x;
        logic signed [31:0] x_milli;
        logic              has_y;
        logic signed [31:0] y_milli;
        logic              has_feed;
        logic [1:0]        feed_preset;
    } out_item_t;

    // per-scanner state seen by the line-end logic
    typedef struct packed {
        logic        found;
        logic        negative;
        logic [31:0] value;
    } scan_res_t;

    // value*10 + d, saturated at MAG_CAP
    function automatic logic [31:0] acc10(input logic [31:0] v, input logic [3:0] d);
        logic [35:0] t;
        t = {v, 3'b000} + {2'b00, v, 1'b0} + {32'd0, d};
        return (t > {4'd0, MAG_CAP}) ? MAG_CAP : t[31:0];
    endfunction

endpackage

>>> src/glp_scanner.sv
// ----------------------------------------------------------------------------
// glp_scanner
// One letter-and-number scanner: latches the first letter followed by a number.
// ----------------------------------------------------------------------------
module glp_scanner #(
    parameter logic [7:0] LETTER      = 8'h47,
    parameter bit         IS_FLOAT    = 1'b0,
    parameter int         FRAC_DIGITS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                clear,
    input  logic [7:0]          c,
    output glp_pkg::scan_res_t  res,
    output logic [2:0]          frac_cnt
);

    glp_pkg::phase_t phase_reg, phase_next;
    logic        found_reg, found_next;
    logic        neg_reg, neg_next;
    logic [31:0] value_reg, value_next;
    logic [2:0]  fd_reg, fd_next;

    logic dig, blank, is_letter;
    logic [31:0] acc;

    assign dig       = (c >= 8'h30) && (c <= 8'h39);
    assign blank     = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
    assign is_letter = ((c & 8'hDF) == LETTER);
    assign acc       = glp_pkg::acc10(value_reg, c[3:0] - 4'd0);

    always_comb
    begin
        phase_next = phase_reg;
        found_next = found_reg;
        neg_next   = neg_reg;
        value_next = value_reg;
        fd_next    = fd_reg;
        case (phase_reg)
            glp_pkg::PH_DONE:
            begin
            end
            glp_pkg::PH_INT:
            begin
                if (dig)
                    value_next = acc;
                else if (IS_FLOAT && c == 8'h2E)
                    phase_next = glp_pkg::PH_FRAC;
                else
                    phase_next = glp_pkg::PH_DONE;
            end
            glp_pkg::PH_FRAC:
            begin
                if (dig)
                begin
                    if (fd_reg < 3'(FRAC_DIGITS))
                    begin
                        value_next = acc;
                        fd_next    = fd_reg + 3'd1;
                    end
                end
                else
                    phase_next = glp_pkg::PH_DONE;
            end
            glp_pkg::PH_LEAD, glp_pkg::PH_SIGNED, glp_pkg::PH_POINT:
            begin
                if (phase_reg == glp_pkg::PH_LEAD && blank)
                begin
                end
                else if (phase_reg == glp_pkg::PH_LEAD && (c == 8'h2B || c == 8'h2D))
                begin
                    neg_next   = (c == 8'h2D);
                    phase_next = glp_pkg::PH_SIGNED;
                end
                else if (dig)
                begin
                    value_next = acc;
                    found_next = 1'b1;
                    if (phase_reg == glp_pkg::PH_POINT)
                    begin
                        if (FRAC_DIGITS > 0)
                            fd_next = 3'd1;
                        else
                            value_next = '0;
                        phase_next = glp_pkg::PH_FRAC;
                    end
                    else
                        phase_next = glp_pkg::PH_INT;
                end
                else if (IS_FLOAT && c == 8'h2E && phase_reg != glp_pkg::PH_POINT)
                    phase_next = glp_pkg::PH_POINT;
                else if (is_letter)
                begin
                    phase_next = glp_pkg::PH_LEAD;
                    neg_next   = 1'b0;
                    value_next = '0;
                    fd_next    = '0;
                end
                else
                    phase_next = glp_pkg::PH_IDLE;
            end
            default:
            begin
                // idle
                if (is_letter)
                begin
                    phase_next = glp_pkg::PH_LEAD;
                    neg_next   = 1'b0;
                    value_next = '0;
                    fd_next    = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= glp_pkg::PH_IDLE;
            found_reg <= 1'b0;
            neg_reg   <= 1'b0;
            value_reg <= '0;
            fd_reg    <= '0;
        end
        else if (clear)
        begin
            phase_reg <= glp_pkg::PH_IDLE;
            found_reg <= 1'b0;
            neg_reg   <= 1'b0;
            value_reg <= '0;
            fd_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            found_reg <= found_next;
            neg_reg   <= neg_next;
            value_reg <= value_next;
            fd_reg    <= IS_FLOAT ? fd_next : 3'd0;
        end
    end

    assign res.found    = found_reg;
    assign res.negative = neg_reg;
    assign res.value    = value_reg;
    assign frac_cnt     = fd_reg;

endmodule

>>> src/gcode_line_parser.sv
// ----------------------------------------------------------------------------
// gcode_line_parser
// Character-serial G-code line parser with one result per line.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one character per transfer, or a transfer with line_end set that
//           closes the line. Characters give no result; a line end gives one.
//   out_* : one result per line: command class, X/Y in thousandths, feed preset.
//   cfg_* : write port for the two feed thresholds, index 0 slow, 1 medium.
// Timing: a character updates the scanners at its transfer edge. At a line end
//   the result is formed combinationally from the scanner state and registered
//   into the result register, or into the skid register while that one is held.
// Throughput: one transfer per cycle while in_ready is high.
//   A line end may directly follow the last character and vice versa.
// Stall: the result register plus one skid register hold up to two results;
//   in_ready drops only while both are full.
// Reset: thresholds return to 300 and 800, all scanners go idle, no comment.
// ----------------------------------------------------------------------------
module gcode_line_parser #(
    parameter int LINE_MAX    = 128,
    parameter int FRAC_DIGITS = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  glp_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output glp_pkg::out_item_t         out_data,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [glp_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int CW = $clog2(LINE_MAX);

    logic [glp_pkg::CFG_W-1:0] slow_reg, medium_reg;
    logic [CW-1:0] count_reg;
    logic in_paren_reg, dead_reg, nonblank_reg;

    logic acc, is_char, is_end, step, counted;
    logic [7:0] c, cf;
    logic [7:0] raw;

    glp_pkg::scan_res_t rg, rm, rx, ry, rf;
    logic [2:0] fdx, fdy, fdg, fdm, fdf;

    glp_pkg::out_item_t res;
    glp_pkg::out_item_t ob_reg, sk_reg;
    logic ob_v_reg, sk_v_reg;

    assign in_ready = !sk_v_reg;
    assign acc      = in_valid && in_ready;
    assign is_end   = in_data.line_end;
    assign is_char  = acc && !is_end;
    assign raw      = in_data.char_byte;
    assign counted  = is_char && (count_reg != CW'(LINE_MAX - 1));

    // comment handling and filtered character
    always_comb
    begin
        cf   = raw;
        step = 1'b0;
        if (counted && !dead_reg)
        begin
            if (in_paren_reg)
            begin
                cf   = 8'h20;
                step = 1'b1;
            end
            else if (raw == 8'h00 || raw == 8'h3B)
                step = 1'b0;
            else
            begin
                step = 1'b1;
                if (raw == 8'h28)
                    cf = 8'h20;
            end
        end
    end
    assign c = cf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            in_paren_reg <= 1'b0;
            dead_reg     <= 1'b0;
            nonblank_reg <= 1'b0;
        end
        else if (acc && is_end)
        begin
            count_reg    <= '0;
            in_paren_reg <= 1'b0;
            dead_reg     <= 1'b0;
            nonblank_reg <= 1'b0;
        end
        else if (counted)
        begin
            count_reg <= count_reg + CW'(1);
            if (!dead_reg)
            begin
                if (in_paren_reg)
                begin
                    if (raw == 8'h29)
                        in_paren_reg <= 1'b0;
                end
                else if (raw == 8'h00 || raw == 8'h3B)
                    dead_reg <= 1'b1;
                else if (raw == 8'h28)
                    in_paren_reg <= 1'b1;
                else if (!(raw == 8'h20 || (raw >= 8'd9 && raw <= 8'd13)))
                    nonblank_reg <= 1'b1;
            end
        end
    end

    logic clr;
    assign clr = acc && is_end;

    glp_scanner #(.LETTER(8'h47), .IS_FLOAT(1'b0), .FRAC_DIGITS(FRAC_DIGITS)) u_g (
        .clk(clk), .rst_n(rst_n), .step(step), .clear(clr), .c(c), .res(rg), .frac_cnt(fdg));
    glp_scanner #(.LETTER(8'h4D), .IS_FLOAT(1'b0), .FRAC_DIGITS(FRAC_DIGITS)) u_m (
        .clk(clk), .rst_n(rst_n), .step(step), .clear(clr), .c(c), .res(rm), .frac_cnt(fdm));
    glp_scanner #(.LETTER(8'h58), .IS_FLOAT(1'b1), .FRAC_DIGITS(FRAC_DIGITS)) u_x (
        .clk(clk), .rst_n(rst_n), .step(step), .clear(clr), .c(c), .res(rx), .frac_cnt(fdx));
    glp_scanner #(.LETTER(8'h59), .IS_FLOAT(1'b1), .FRAC_DIGITS(FRAC_DIGITS)) u_y (
        .clk(clk), .rst_n(rst_n), .step(step), .clear(clr), .c(c), .res(ry), .frac_cnt(fdy));
    glp_scanner #(.LETTER(8'h46), .IS_FLOAT(1'b0), .FRAC_DIGITS(FRAC_DIGITS)) u_f (
        .clk(clk), .rst_n(rst_n), .step(step), .clear(clr), .c(c), .res(rf), .frac_cnt(fdf));

    // scale by 10 per missing fraction digit, at most FRAC_DIGITS constant steps
    function automatic logic [31:0] coord(input glp_pkg::scan_res_t r, input logic [2:0] fd);
        logic [31:0] m;
        m = r.value;
        for (int i = 0; i < FRAC_DIGITS; i++)
            if (3'(i) >= fd)
                m = glp_pkg::acc10(m, 4'd0);
        if (r.negative)
            return 32'd0 - m;
        return (m > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m;
    endfunction

    function automatic logic code_is(input glp_pkg::scan_res_t r, input logic [31:0] n);
        return (r.value == n) && (n == 32'd0 || !r.negative);
    endfunction

    always_comb
    begin
        logic coords;
        res    = '0;
        coords = 1'b1;
        if (nonblank_reg)
        begin
            if (rg.found)
            begin
                if (code_is(rg, 32'd0))
                    res.command = glp_pkg::CMD_G0;
                else if (code_is(rg, 32'd1))
                    res.command = glp_pkg::CMD_G1;
                else if (code_is(rg, 32'd28))
                begin
                    res.command = glp_pkg::CMD_G28;
                    coords = 1'b0;
                end
                else if (code_is(rg, 32'd92))
                    res.command = glp_pkg::CMD_G92;
                else
                begin
                    res.command = glp_pkg::CMD_ERR;
                    coords = 1'b0;
                end
            end
            if (coords && rm.found)
            begin
                res.command = code_is(rm, 32'd2) ? glp_pkg::CMD_M2 : glp_pkg::CMD_ERR;
                coords = 1'b0;
            end
            if (res.command == glp_pkg::CMD_BLANK)
            begin
                res.command = glp_pkg::CMD_ERR;
                coords = 1'b0;
            end
            res.status = (res.command == glp_pkg::CMD_ERR);
            if (coords)
            begin
                if (rx.found)
                begin
                    res.has_x   = 1'b1;
                    res.x_milli = coord(rx, fdx);
                end
                if (ry.found)
                begin
                    res.has_y   = 1'b1;
                    res.y_milli = coord(ry, fdy);
                end
                if (rf.found)
                begin
                    res.has_feed = 1'b1;
                    if (rf.negative || rf.value <= {12'd0, slow_reg})
                        res.feed_preset = glp_pkg::FEED_SLOW;
                    else if (rf.value <= {12'd0, medium_reg})
                        res.feed_preset = glp_pkg::FEED_MEDIUM;
                    else
                        res.feed_preset = glp_pkg::FEED_FAST;
                end
            end
        end
    end

    // result register with skid stage; the skid only fills while in_ready is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_v_reg <= 1'b0;
            sk_v_reg <= 1'b0;
        end
        else
        begin
            if (!ob_v_reg || out_ready)
            begin
                ob_v_reg <= sk_v_reg || clr;
                sk_v_reg <= 1'b0;
            end
            else if (clr)
                sk_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ob_v_reg || out_ready)
            ob_reg <= sk_v_reg ? sk_reg : res;
        else if (clr)
            sk_reg <= res;
    end

    logic unused_fd;
    assign unused_fd = ^{fdg, fdm, fdf};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_reg   <= glp_pkg::CFG_W'(300);
            medium_reg <= glp_pkg::CFG_W'(800);
        end
        else if (cfg_we)
        begin
            if (cfg_index == glp_pkg::CFG_SLOW)
                slow_reg <= cfg_wdata;
            else if (cfg_index == glp_pkg::CFG_MEDIUM)
                medium_reg <= cfg_wdata;
        end
    end

    assign out_valid = ob_v_reg;
    assign out_data  = ob_reg;

endmodule

>>> dv/gcode_line_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcode_line_parser_tb
// Drives G-code lines one character per transfer, predicts each line result
// with a behavioral line scanner and compares every output field in order.
// ----------------------------------------------------------------------------
module gcode_line_parser_tb;

    localparam int  LINE_LIMIT = 128;
    localparam int  FRAC_N     = 3;
    localparam int  N_RANDOM   = 1030;
    localparam longint CYCLE_LIMIT = 400000;

    localparam int SCN_G = 0;
    localparam int SCN_M = 1;
    localparam int SCN_X = 2;
    localparam int SCN_Y = 3;
    localparam int SCN_F = 4;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    glp_pkg::in_item_t          in_data;
    logic                       out_valid;
    logic                       out_ready;
    glp_pkg::out_item_t         out_data;
    logic                       cfg_we;
    logic                       cfg_index;
    logic [glp_pkg::CFG_W-1:0]  cfg_wdata;

    gcode_line_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // line scanner state of the predictor
    logic [19:0]       slow_lim;
    logic [19:0]       med_lim;
    logic              in_paren;
    logic              line_dead;
    int unsigned       chars_taken;
    logic              nonblank;
    glp_pkg::phase_t   sc_phase [5];
    logic              sc_found [5];
    logic              sc_neg [5];
    logic [31:0]       sc_mag [5];
    int unsigned       frac_cnt [2];

    glp_pkg::out_item_t expected_lines[$];
    int            n_errors;
    int            n_lines;
    int            n_chars;
    longint        cycles;
    bit            hold_off;
    bit            no_idle;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic bit blank_char(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [31:0] times10_plus(input logic [31:0] v, input logic [7:0] c);
        logic [63:0] t;
        t = {32'd0, v} * 64'd10 + {56'd0, c - 8'h30};
        return (t > 64'h8000_0000) ? 32'h8000_0000 : t[31:0];
    endfunction

    task automatic clear_line_state();
        in_paren = 1'b0;
        line_dead = 1'b0;
        chars_taken = 0;
        nonblank = 1'b0;
        for (int k = 0; k < 5; k++)
        begin
            sc_phase[k] = glp_pkg::PH_IDLE;
            sc_found[k] = 1'b0;
            sc_neg[k] = 1'b0;
            sc_mag[k] = '0;
        end
        frac_cnt[0] = 0;
        frac_cnt[1] = 0;
    endtask

    task automatic letter_or_idle(input int k, input logic [7:0] c);
        logic [7:0] letters [5];
        letters = '{8'h47, 8'h4D, 8'h58, 8'h59, 8'h46};
        if ((c & 8'hDF) == letters[k])
        begin
            sc_phase[k] = glp_pkg::PH_LEAD;
            sc_neg[k] = 1'b0;
            sc_mag[k] = '0;
            if (k == SCN_X || k == SCN_Y)
                frac_cnt[k - SCN_X] = 0;
        end
        else
            sc_phase[k] = glp_pkg::PH_IDLE;
    endtask

    task automatic scan_char(input int k, input logic [7:0] c);
        bit is_coord;
        bit is_digit;
        glp_pkg::phase_t ph;
        is_coord = (k == SCN_X || k == SCN_Y);
        is_digit = (c >= 8'h30 && c <= 8'h39);
        ph = sc_phase[k];
        if (ph == glp_pkg::PH_DONE)
            return;
        if (ph == glp_pkg::PH_IDLE)
        begin
            letter_or_idle(k, c);
            return;
        end
        if (ph == glp_pkg::PH_INT)
        begin
            if (is_digit) sc_mag[k] = times10_plus(sc_mag[k], c);
            else if (is_coord && c == ".") sc_phase[k] = glp_pkg::PH_FRAC;
            else sc_phase[k] = glp_pkg::PH_DONE;
            return;
        end
        if (ph == glp_pkg::PH_FRAC)
        begin
            if (is_digit)
            begin
                if (frac_cnt[k - SCN_X] < FRAC_N)
                begin
                    sc_mag[k] = times10_plus(sc_mag[k], c);
                    frac_cnt[k - SCN_X]++;
                end
            end
            else
                sc_phase[k] = glp_pkg::PH_DONE;
            return;
        end
        if (ph == glp_pkg::PH_LEAD && blank_char(c))
            return;
        if (ph == glp_pkg::PH_LEAD && (c == "+" || c == "-"))
        begin
            sc_neg[k] = (c == "-");
            sc_phase[k] = glp_pkg::PH_SIGNED;
            return;
        end
        if (is_digit)
        begin
            sc_mag[k] = times10_plus(sc_mag[k], c);
            sc_found[k] = 1'b1;
            if (ph == glp_pkg::PH_POINT)
            begin
                frac_cnt[k - SCN_X] = 1;
                sc_phase[k] = glp_pkg::PH_FRAC;
            end
            else
                sc_phase[k] = glp_pkg::PH_INT;
            return;
        end
        if (is_coord && c == "." && ph != glp_pkg::PH_POINT)
        begin
            sc_phase[k] = glp_pkg::PH_POINT;
            return;
        end
        letter_or_idle(k, c);
    endtask

    function automatic bit code_equals(input int k, input logic [31:0] n);
        return sc_mag[k] == n && (n == 0 || !sc_neg[k]);
    endfunction

    function automatic logic [31:0] coord_milli(input int k);
        logic [63:0] mag;
        mag = {32'd0, sc_mag[k]};
        for (int i = frac_cnt[k - SCN_X]; i < FRAC_N; i++)
        begin
            mag = mag * 10;
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        end
        if (sc_neg[k])
            return 32'd0 - mag[31:0];
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    // advance the predictor by one transfer; a line end queues its result
    task automatic predict_transfer(input glp_pkg::in_item_t it);
        logic [7:0] c;
        glp_pkg::out_item_t r;
        bit coords;
        c = it.char_byte;
        if (!it.line_end)
        begin
            if (chars_taken >= LINE_LIMIT - 1) return;
            chars_taken++;
            if (line_dead) return;
            if (in_paren)
            begin
                if (c == ")") in_paren = 1'b0;
                c = " ";
            end
            else if (c == 8'd0 || c == ";")
            begin
                line_dead = 1'b1;
                return;
            end
            else if (c == "(")
            begin
                in_paren = 1'b1;
                c = " ";
            end
            if (!blank_char(c)) nonblank = 1'b1;
            for (int k = 0; k < 5; k++) scan_char(k, c);
            return;
        end
        r = '0;
        r.command = glp_pkg::CMD_BLANK;
        if (nonblank)
        begin
            coords = 1'b1;
            if (sc_found[SCN_G])
            begin
                if (code_equals(SCN_G, 0)) r.command = glp_pkg::CMD_G0;
                else if (code_equals(SCN_G, 1)) r.command = glp_pkg::CMD_G1;
                else if (code_equals(SCN_G, 28))
                begin
                    r.command = glp_pkg::CMD_G28;
                    coords = 1'b0;
                end
                else if (code_equals(SCN_G, 92)) r.command = glp_pkg::CMD_G92;
                else
                begin
                    r.command = glp_pkg::CMD_ERR;
                    coords = 1'b0;
                end
            end
            if (coords && sc_found[SCN_M])
            begin
                r.command = code_equals(SCN_M, 2) ? glp_pkg::CMD_M2 : glp_pkg::CMD_ERR;
                coords = 1'b0;
            end
            if (r.command == glp_pkg::CMD_BLANK)
            begin
                r.command = glp_pkg::CMD_ERR;
                coords = 1'b0;
            end
            r.status = (r.command == glp_pkg::CMD_ERR);
            if (coords)
            begin
                if (sc_found[SCN_X])
                begin
                    r.has_x = 1'b1;
                    r.x_milli = coord_milli(SCN_X);
                end
                if (sc_found[SCN_Y])
                begin
                    r.has_y = 1'b1;
                    r.y_milli = coord_milli(SCN_Y);
                end
                if (sc_found[SCN_F])
                begin
                    r.has_feed = 1'b1;
                    if (sc_neg[SCN_F] || sc_mag[SCN_F] <= {12'd0, slow_lim})
                        r.feed_preset = glp_pkg::FEED_SLOW;
                    else if (sc_mag[SCN_F] <= {12'd0, med_lim})
                        r.feed_preset = glp_pkg::FEED_MEDIUM;
                    else
                        r.feed_preset = glp_pkg::FEED_FAST;
                end
            end
        end
        expected_lines.push_back(r);
        clear_line_state();
    endtask

    // output side: check each result transfer, random stalls and one long hold-off
    always @(posedge clk)
    begin
        glp_pkg::out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_lines.size() == 0)
            begin
                $error("unexpected result transfer");
                n_errors++;
            end
            else
            begin
                e = expected_lines.pop_front();
                n_lines++;
                if (out_data.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, out_data.status);
                    n_errors++;
                end
                if (out_data.command !== e.command)
                begin
                    $error("command exp %0d got %0d", e.command, out_data.command);
                    n_errors++;
                end
                if (out_data.has_x !== e.has_x)
                begin
                    $error("has_x exp %0d got %0d", e.has_x, out_data.has_x);
                    n_errors++;
                end
                if (out_data.x_milli !== e.x_milli)
                begin
                    $error("x_milli exp %0d got %0d", e.x_milli, out_data.x_milli);
                    n_errors++;
                end
                if (out_data.has_y !== e.has_y)
                begin
                    $error("has_y exp %0d got %0d", e.has_y, out_data.has_y);
                    n_errors++;
                end
                if (out_data.y_milli !== e.y_milli)
                begin
                    $error("y_milli exp %0d got %0d", e.y_milli, out_data.y_milli);
                    n_errors++;
                end
                if (out_data.has_feed !== e.has_feed)
                begin
                    $error("has_feed exp %0d got %0d", e.has_feed, out_data.has_feed);
                    n_errors++;
                end
                if (out_data.feed_preset !== e.feed_preset)
                begin
                    $error("feed_preset exp %0d got %0d", e.feed_preset,
                           out_data.feed_preset);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
            out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 11);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("gcode_line_parser_tb failed");
            $finish;
        end
    end

    // one transfer with random idle cycles before it; valid stays up between items when none are drawn
    task automatic send_item(input logic [7:0] c, input logic le);
        glp_pkg::in_item_t it;
        it.char_byte = c;
        it.line_end = le;
        while (!no_idle && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_transfer(it);
        n_chars++;
        @(negedge clk);
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
        send_item(8'd0, 1'b1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_lines.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic idx, input logic [19:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge clk);
        if (idx == glp_pkg::CFG_SLOW) slow_lim = v;
        else med_lim = v;
    endtask

    function automatic string rand_number(input bit coord);
        string s;
        int nd;
        s = "";
        case ($urandom_range(3))
            0: s = {s, "-"};
            1: s = {s, "+"};
            2: s = {s, " "};
            default: ;
        endcase
        nd = ($urandom_range(9) == 0) ? $urandom_range(14) : $urandom_range(1, 4);
        for (int i = 0; i < nd; i++) s = {s, string'(8'h30 + 8'($urandom_range(9)))};
        if (coord && $urandom_range(1))
        begin
            s = {s, "."};
            nd = $urandom_range(5);
            for (int i = 0; i < nd; i++)
                s = {s, string'(8'h30 + 8'($urandom_range(9)))};
        end
        return s;
    endfunction

    function automatic string rand_line();
        string s;
        string codes [6];
        int nw;
        codes = '{"0", "1", "28", "92", "-0", "3"};
        s = "";
        if ($urandom_range(9) < 7)
        begin
            // well-formed line with random content
            if ($urandom_range(4) != 0)
                s = {($urandom_range(1) ? "G" : "g"), codes[$urandom_range(5)]};
            if ($urandom_range(5) == 0) s = {s, " M", ($urandom_range(1) ? "2" : "5")};
            if ($urandom_range(3) != 0) s = {s, " X", rand_number(1)};
            if ($urandom_range(3) != 0) s = {s, " y", rand_number(1)};
            if ($urandom_range(2) == 0) s = {s, " F", rand_number(0)};
            if ($urandom_range(5) == 0) s = {s, " (note)"};
            if ($urandom_range(6) == 0) s = {s, " ; tail X5"};
        end
        else
        begin
            nw = $urandom_range(30);
            for (int i = 0; i < nw; i++)
                s = {s, string'(8'($urandom_range(255)))};
        end
        return s;
    endfunction

    typedef struct {
        string      text;
        bit         check_direct;
        logic [2:0] cmd;
    } vector_t;

    initial
    begin
        vector_t vectors [];
        int total;
        string s;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = glp_pkg::CFG_SLOW;
        cfg_wdata = '0;
        n_errors = 0;
        n_lines = 0;
        n_chars = 0;
        cycles = 0;
        hold_off = 1'b0;
        no_idle = 1'b0;
        slow_lim = 20'd300;
        med_lim = 20'd800;
        clear_line_state();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        vectors = '{
            '{"", 1, glp_pkg::CMD_BLANK},
            '{"   (only a comment)", 1, glp_pkg::CMD_BLANK},
            '{"; whole line dead", 1, glp_pkg::CMD_BLANK},
            '{"X1 Y2", 1, glp_pkg::CMD_ERR},
            '{"G5", 1, glp_pkg::CMD_ERR},
            '{"G-1", 1, glp_pkg::CMD_ERR},
            '{"M3", 1, glp_pkg::CMD_ERR},
            '{"G28 X5", 1, glp_pkg::CMD_G28},
            '{"G1 M2", 1, glp_pkg::CMD_M2},
            '{"G0 X1.5 Y-2.25 F100", 0, glp_pkg::CMD_BLANK},
            '{"g1 x+ 12.3456 y.5 f 500", 0, glp_pkg::CMD_BLANK},
            '{"G-0 X-0 F-7", 0, glp_pkg::CMD_BLANK},
            '{"G92 X99999999999 Y-99999999999", 0, glp_pkg::CMD_BLANK},
            '{"G1 X2147483.647 Y-2147483.648 F1000000", 0, glp_pkg::CMD_BLANK},
            '{"G1 X1e5 Y0x10 Finf", 0, glp_pkg::CMD_BLANK},
            '{"G1 (unclosed X5", 0, glp_pkg::CMD_BLANK},
            '{"G0 X. Y-. X3", 0, glp_pkg::CMD_BLANK},
            '{"G1 F300", 0, glp_pkg::CMD_BLANK},
            '{"G1 F301", 0, glp_pkg::CMD_BLANK},
            '{"G1 F801", 0, glp_pkg::CMD_BLANK},
            '{"G1 X\xff\x80Y4", 0, glp_pkg::CMD_BLANK}
        };
        foreach (vectors[i])
        begin
            send_line(vectors[i].text);
            if (vectors[i].check_direct &&
                expected_lines[expected_lines.size()-1].command != vectors[i].cmd)
            begin
                $error("command exp %0d got %0d (table)", vectors[i].cmd,
                       expected_lines[expected_lines.size()-1].command);
                n_errors++;
            end
        end
        // zero byte kills the rest of the line
        send_item("G", 1'b0);
        send_item("1", 1'b0);
        send_item(8'd0, 1'b0);
        send_item("M", 1'b0);
        send_item(8'd0, 1'b1);
        // line longer than the LINE_LIMIT character limit
        s = "G1 X1";
        while (s.len() < LINE_LIMIT + 10) s = {s, " "};
        s = {s, "Y7"};
        send_line(s);
        drain();

        // sweep the thresholds, extremes included
        total = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_limit(glp_pkg::CFG_SLOW, 20'd0);
                    write_limit(glp_pkg::CFG_MEDIUM, 20'd0);
                end
                1:
                begin
                    write_limit(glp_pkg::CFG_SLOW, 20'd1000000);
                    write_limit(glp_pkg::CFG_MEDIUM, 20'hFFFFF);
                end
                2:
                begin
                    write_limit(glp_pkg::CFG_SLOW, 20'd50);
                    write_limit(glp_pkg::CFG_MEDIUM, 20'd5000);
                end
                default:
                begin
                    write_limit(glp_pkg::CFG_SLOW, 20'd300);
                    write_limit(glp_pkg::CFG_MEDIUM, 20'd800);
                end
            endcase
            cfg_we <= 1'b0;
            if (phase == 1) hold_off = 1'b1;
            no_idle = (phase == 2);
            while (total < (phase + 1) * N_RANDOM / 4)
            begin
                s = rand_line();
                send_line(s);
                total += s.len() + 1;
            end
            // sender waits for all results before the next phase
            drain();
        end

        repeat (20) @(negedge clk);
        $display("covered %0d transfers and %0d line results over 4 threshold settings",
                 n_chars, n_lines);
        if (n_errors == 0 && expected_lines.size() == 0)
            $display("gcode_line_parser_tb passed");
        else
            $display("gcode_line_parser_tb failed");
        $finish;
    end

endmodule

>>> sim.f
src/glp_pkg.sv
src/glp_scanner.sv
src/gcode_line_parser.sv
dv/gcode_line_parser_tb.sv
